// ===== rtl/mtf_pkg.sv =====
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types for the move-to-front identifier list: the identifier word and
// the control bundle between the scan controller and the list store.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int unsigned IdW = 32;

  typedef logic [IdW-1:0] id_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mtf_mem_ctrl_t;

endpackage

// ===== rtl/mtf_store.sv =====
// ----------------------------------------------------------------------------
// mtf_store
// Synchronous list store: one write and one read port, registered read data.
// Entries never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module mtf_store #(
  parameter int unsigned Depth = 5,
  parameter int unsigned AddrW = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mtf_pkg::mtf_mem_ctrl_t ctrl_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  mtf_pkg::id_t          wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output mtf_pkg::id_t          rdata_o
);
  import mtf_pkg::*;

  id_t              mem_q [Depth];
  id_t              rdata_q;
  logic [Depth-1:0] valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[raddr_i];
      end
    end
  end

  // Unwritten entries read as zero through their valid bits
  assign rdata_o = rd_valid_q ? rdata_q : '0;

endmodule

// ===== rtl/move_to_front_id_list.sv =====
// ----------------------------------------------------------------------------
// move_to_front_id_list
// Fixed-depth list of 32-bit identifiers kept in most-recently-seen order.
// Each lookup walks the list from the front, shifting entries down one place,
// until it finds the identifier or drops the last entry; the identifier lands
// at the front and the result flags whether it was new.
//
//   channel  | valid       | stall        | payload
//   ---------+-------------+--------------+-------------
//   input    | in_valid_i  | in_stall_o   | lookup_id_i
//   output   | out_valid_o | out_stall_i  | is_new_o
//
// A lookup walks from the front to the hit position (LIST_DEPTH - 1 on a
// miss) before the next input transfer can be taken: the list
// store has one read and one write port, so the walk handles one entry a cycle.
// The result sits in an output register; a new lookup is taken while it waits.
// If the previous result is still stalled when a walk ends, the new result is
// held until the output register frees up. Reset empties the list (all zeros).
// ----------------------------------------------------------------------------
module move_to_front_id_list #(
  parameter int unsigned LIST_DEPTH = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  mtf_pkg::id_t lookup_id_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         is_new_o
);
  import mtf_pkg::*;

  localparam int unsigned AddrW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(LIST_DEPTH - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic             is_new_q, is_new_d;
  logic             res_q, res_d;
  id_t              key_q;
  id_t              carry_q, carry_d;

  mtf_mem_ctrl_t    mem_ctrl;
  logic [AddrW-1:0] raddr;
  id_t              entry;
  logic             in_xfer;
  logic             hit;
  logic             done;
  logic             out_free;

  mtf_store #(
    .Depth (LIST_DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mem_ctrl),
    .waddr_i (idx_q),
    .wdata_i (carry_q),
    .raddr_i (raddr),
    .rdata_o (entry)
  );

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && (state_q == StIdle);
  assign hit        = (entry == key_q);
  assign done       = hit || (idx_q == LastIdx);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    carry_d        = carry_q;
    res_d          = res_q;
    is_new_d       = is_new_q;
    out_valid_d    = out_valid_q;
    mem_ctrl.rd_en = 1'b0;
    mem_ctrl.wr_en = 1'b0;
    raddr          = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mem_ctrl.rd_en = 1'b1;
          idx_d          = '0;
          carry_d        = lookup_id_i;
          state_d        = StScan;
        end
      end
      StScan: begin
        // Write the carried identifier here and pick up the displaced entry
        mem_ctrl.wr_en = 1'b1;
        carry_d        = entry;
        if (done) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            is_new_d    = !hit;
            state_d     = StIdle;
          end else begin
            res_d   = !hit;
            state_d = StHold;
          end
        end else begin
          idx_d          = idx_q + 1'b1;
          raddr          = idx_q + 1'b1;
          mem_ctrl.rd_en = 1'b1;
        end
      end
      StHold: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          is_new_d    = res_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q <= lookup_id_i;
    end
    carry_q  <= carry_d;
    res_q    <= res_d;
    is_new_q <= is_new_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_new_o    = is_new_q;

endmodule
